>>> src/cdsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsu_pkg: shared types, constants and table functions
// Operation and error codes, pipeline stage payloads and the small calendar
// tables that are used by the date step pipeline.
// ----------------------------------------------------------------------------
package cdsu_pkg;

  typedef enum logic [2:0] {
    FUNC_NEXT_DAY   = 3'd0,
    FUNC_PREV_DAY   = 3'd1,
    FUNC_NEXT_MONTH = 3'd2,
    FUNC_PREV_MONTH = 3'd3,
    FUNC_ADD_YEARS  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_DATE  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  localparam logic [13:0] YEAR_MIN     = 14'd1;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [4:0]  DAYS_DEC     = 5'd31;
  localparam logic [2:0]  WD_FRIDAY    = 3'd5;
  localparam logic [2:0]  WD_SATURDAY  = 3'd6;

  // floor(y / 100) for y < 43690: (y * 5243) >> 19
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  // floor(s / 7) for s < 43690: (s * 18725) >> 17
  localparam logic [14:0] DIV7_MUL     = 15'd18725;
  localparam int unsigned DIV7_SHIFT   = 17;

  typedef struct packed {
    logic s1;
    logic s2;
  } step_en_t;

  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } derive_en_t;

  // first stage: decoded request with year quotient and offset sum
  typedef struct packed {
    logic [2:0]         func;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [7:0]         year_q;
    logic signed [15:0] year_sum;
  } s1_t;

  // result date as chosen by the step logic
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    err_e        err;
    logic        inv;
  } date_t;

  typedef struct packed {
    date_t       dt;
    logic [13:0] yy;
    logic [7:0]  year_q;
    logic [7:0]  yy_q;
  } s3_t;

  typedef struct packed {
    date_t       dt;
    logic [8:0]  doy;
    logic [4:0]  mlen;
    logic        leap;
    logic [13:0] wsum;
  } s4_t;

  typedef struct packed {
    s4_t         b;
    logic [10:0] wq;
  } s5_t;

  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [26:0] p;
    p = 27'(y) * 27'(DIV100_MUL);
    return p[DIV100_SHIFT +: 8];
  endfunction

  function automatic logic is_leap(input logic [13:0] y, input logic [7:0] q);
    logic [13:0] hund;
    hund = 14'(14'(q) * 14'd100);
    return (y[1:0] == 2'b00) && ((y != hund) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // (31 * mm) / 12 with mm the March-based month number
  function automatic logic [4:0] wd_month_term(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/cdsu_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsu_step: request decode and date step
// Stage 1 registers the request with the year quotient and the offset sum.
// Stage 2 validates the date, applies the operation and range check.
// ----------------------------------------------------------------------------
module cdsu_step (
  input  logic                  clk_i,
  input  cdsu_pkg::step_en_t    en_i,
  input  logic [2:0]            func_i,
  input  logic [13:0]           year_i,
  input  logic [3:0]            month_i,
  input  logic [4:0]            day_i,
  input  logic signed [14:0]    year_offset_i,
  output cdsu_pkg::date_t       date_o
);

  cdsu_pkg::s1_t   s1_d, s1_q;
  cdsu_pkg::date_t s2_d, s2_q;

  logic               leap;
  logic [4:0]         mlen;
  logic [4:0]         mlen_n;
  logic               valid;
  logic               range_bad;
  logic signed [15:0] yr;
  logic signed [15:0] ny;
  logic [3:0]         nm;
  logic [4:0]         nd;

  always_comb begin
    s1_d.func     = func_i;
    s1_d.year     = year_i;
    s1_d.month    = month_i;
    s1_d.day      = day_i;
    s1_d.year_q   = cdsu_pkg::div100(year_i);
    s1_d.year_sum = $signed({2'b00, year_i}) + $signed({year_offset_i[14], year_offset_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    leap   = cdsu_pkg::is_leap(s1_q.year, s1_q.year_q);
    mlen   = cdsu_pkg::month_len(s1_q.month, leap);
    valid  = (s1_q.year >= cdsu_pkg::YEAR_MIN) && (s1_q.year <= cdsu_pkg::YEAR_MAX) &&
             (s1_q.day != 5'd0) && (s1_q.day <= mlen);
    yr     = $signed({2'b00, s1_q.year});
    ny     = yr;
    nm     = s1_q.month;
    nd     = s1_q.day;
    mlen_n = 5'd0;
    unique case (s1_q.func)
      cdsu_pkg::FUNC_NEXT_DAY: begin
        if (s1_q.day == mlen) begin
          nd = 5'd1;
          if (s1_q.month == cdsu_pkg::MONTH_DEC) begin
            nm = cdsu_pkg::MONTH_JAN;
            ny = yr + 16'sd1;
          end else begin
            nm = s1_q.month + 4'd1;
          end
        end else begin
          nd = s1_q.day + 5'd1;
        end
      end
      cdsu_pkg::FUNC_PREV_DAY: begin
        if (s1_q.day == 5'd1) begin
          if (s1_q.month == cdsu_pkg::MONTH_JAN) begin
            ny = yr - 16'sd1;
            nm = cdsu_pkg::MONTH_DEC;
            nd = cdsu_pkg::DAYS_DEC;
          end else begin
            nm = s1_q.month - 4'd1;
            nd = cdsu_pkg::month_len(nm, leap);
          end
        end else begin
          nd = s1_q.day - 5'd1;
        end
      end
      cdsu_pkg::FUNC_NEXT_MONTH, cdsu_pkg::FUNC_PREV_MONTH: begin
        if (s1_q.func == cdsu_pkg::FUNC_NEXT_MONTH) begin
          if (s1_q.month == cdsu_pkg::MONTH_DEC) begin
            nm = cdsu_pkg::MONTH_JAN;
            ny = yr + 16'sd1;
          end else begin
            nm = s1_q.month + 4'd1;
          end
        end else begin
          if (s1_q.month == cdsu_pkg::MONTH_JAN) begin
            nm = cdsu_pkg::MONTH_DEC;
            ny = yr - 16'sd1;
          end else begin
            nm = s1_q.month - 4'd1;
          end
        end
        // February is only reached within the same year, so the input leap flag holds
        mlen_n = cdsu_pkg::month_len(nm, leap);
        if (nd > mlen_n) begin
          nd = mlen_n;
        end
      end
      cdsu_pkg::FUNC_ADD_YEARS: begin
        ny = s1_q.year_sum;
      end
      default: begin
      end
    endcase
    range_bad = (ny < 16'sd1) || (ny > 16'sd9999);

    if (!valid) begin
      s2_d = '{year: s1_q.year, month: s1_q.month, day: s1_q.day,
               err: cdsu_pkg::ERR_DATE, inv: 1'b1};
    end else if (range_bad) begin
      s2_d = '{year: s1_q.year, month: s1_q.month, day: s1_q.day,
               err: cdsu_pkg::ERR_RANGE, inv: 1'b0};
    end else begin
      s2_d = '{year: ny[13:0], month: nm, day: nd, err: cdsu_pkg::ERR_OK, inv: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_q <= s2_d;
    end
  end

  assign date_o = s2_q;

endmodule

>>> src/cdsu_derive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsu_derive: derived fields of the result date
// Stage 3 takes year quotients, stage 4 forms leap flag, month length,
// day of year and the weekday sum, stage 5 the quotient of that sum by 7.
// ----------------------------------------------------------------------------
module cdsu_derive (
  input  logic                  clk_i,
  input  cdsu_pkg::derive_en_t  en_i,
  input  cdsu_pkg::date_t       date_i,
  output cdsu_pkg::s5_t         s5_o
);

  cdsu_pkg::s3_t s3_d, s3_q;
  cdsu_pkg::s4_t s4_d, s4_q;
  cdsu_pkg::s5_t s5_d, s5_q;

  logic        jan_feb;
  logic        in_month;
  logic        late_leap;
  logic [28:0] wprod;

  always_comb begin
    // January and February count as months of the previous year
    jan_feb     = (date_i.month == cdsu_pkg::MONTH_JAN) ||
                  (date_i.month == cdsu_pkg::MONTH_FEB);
    s3_d.dt     = date_i;
    s3_d.yy     = date_i.year - {13'd0, jan_feb};
    s3_d.year_q = cdsu_pkg::div100(date_i.year);
    s3_d.yy_q   = cdsu_pkg::div100(s3_d.yy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_q <= s3_d;
    end
  end

  always_comb begin
    s4_d.dt   = s3_q.dt;
    s4_d.leap = cdsu_pkg::is_leap(s3_q.dt.year, s3_q.year_q);
    s4_d.mlen = cdsu_pkg::month_len(s3_q.dt.month, s4_d.leap);
    in_month  = (s3_q.dt.day != 5'd0) && (s3_q.dt.day <= s4_d.mlen);
    late_leap = (s3_q.dt.month > cdsu_pkg::MONTH_FEB) && s4_d.leap;
    if (in_month && !s3_q.dt.inv) begin
      s4_d.doy = cdsu_pkg::cum_days(s3_q.dt.month) + {4'd0, s3_q.dt.day} + {8'd0, late_leap};
    end else begin
      s4_d.doy = 9'd0;
    end
    s4_d.wsum = {9'd0, s3_q.dt.day} + s3_q.yy + {2'd0, s3_q.yy[13:2]} -
                {6'd0, s3_q.yy_q} + {8'd0, s3_q.yy_q[7:2]} +
                {9'd0, cdsu_pkg::wd_month_term(s3_q.dt.month)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      s4_q <= s4_d;
    end
  end

  always_comb begin
    wprod   = 29'(s4_q.wsum) * 29'(cdsu_pkg::DIV7_MUL);
    s5_d.b  = s4_q;
    s5_d.wq = wprod[cdsu_pkg::DIV7_SHIFT +: 11];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      s5_q <= s5_d;
    end
  end

  assign s5_o = s5_q;

endmodule

>>> src/calendar_date_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_step_unit: Gregorian date step pipeline
// Steps a date by one day, one month or a signed number of years and
// returns the new date with weekday, day of year, month length and flags.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on the s_axis channel: operation, date and year offset
//   packed in s_axis_tdata. The result leaves on m_axis as one item.
//   Pipeline: six register stages; the first loads at the edge at which the
//   request is accepted and the last is the output register.
//   Throughput: one request per cycle. Each stage holds one request and
//   passes it on in the next cycle while the output keeps moving.
//   Stall: when m_axis_tready is low the output holds; stages behind it keep
//   filling until every stage is occupied, and only then s_axis_tready drops.
//   No request is lost or repeated.
//   Reset: rst_ni low empties the pipeline and drops m_axis_tvalid; the
//   block takes requests as soon as reset is released.
//   Invalid input dates come back unchanged with error code 1; a year that
//   would leave 1..9999 keeps the input date with error code 2.
// ----------------------------------------------------------------------------
module calendar_date_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] func, [16:3] year, [20:17] month, [25:21] day,
  // [40:26] year_offset (signed), [47:41] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] new_year, [17:14] new_month, [22:18] new_day, [25:23] weekday,
  // [34:26] day_of_year, [39:35] month_length, [40] leap_year, [41] weekend,
  // [43:42] error, [47:44] zero
  output logic [47:0] m_axis_tdata
);

  logic [5:1] v_d, v_q;
  logic [6:1] rdy;
  logic       out_v_d, out_v_q;
  logic [47:0] out_d, out_q;

  cdsu_pkg::step_en_t   step_en;
  cdsu_pkg::derive_en_t derive_en;
  cdsu_pkg::date_t      s2_date;
  cdsu_pkg::s5_t        s5;

  logic [13:0] wd_full;
  logic [2:0]  wd;
  logic        weekend;

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    rdy[6] = !out_v_q || m_axis_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[1] = rdy[1] ? s_axis_tvalid : v_q[1];
    for (int k = 2; k <= 5; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
    out_v_d = rdy[6] ? v_q[5] : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= v_d;
      out_v_q <= out_v_d;
    end
  end

  assign step_en   = '{s1: rdy[1], s2: rdy[2]};
  assign derive_en = '{s3: rdy[3], s4: rdy[4], s5: rdy[5]};

  cdsu_step u_step (
    .clk_i         (clk_i),
    .en_i          (step_en),
    .func_i        (s_axis_tdata[2:0]),
    .year_i        (s_axis_tdata[16:3]),
    .month_i       (s_axis_tdata[20:17]),
    .day_i         (s_axis_tdata[25:21]),
    .year_offset_i ($signed(s_axis_tdata[40:26])),
    .date_o        (s2_date)
  );

  cdsu_derive u_derive (
    .clk_i  (clk_i),
    .en_i   (derive_en),
    .date_i (s2_date),
    .s5_o   (s5)
  );

  always_comb begin
    wd_full = s5.b.wsum - 14'(14'(s5.wq) * 14'd7);
    wd      = s5.b.dt.inv ? 3'd0 : wd_full[2:0];
    weekend = (wd == cdsu_pkg::WD_FRIDAY) || (wd == cdsu_pkg::WD_SATURDAY);
    out_d   = {4'd0, s5.b.dt.err, weekend, s5.b.leap, s5.b.mlen, s5.b.doy, wd,
               s5.b.dt.day, s5.b.dt.month, s5.b.dt.year};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> src/cdsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsu_checker: port-level checks for the date step unit
// Watches the result channel for consistent error, weekday and flag fields
// and for a held result under backpressure.
// ----------------------------------------------------------------------------
module cdsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic [2:0] wd;
  logic [1:0] err;
  logic [8:0] doy;

  assign wd  = m_axis_tdata[25:23];
  assign err = m_axis_tdata[43:42];
  assign doy = m_axis_tdata[34:26];

  // an invalid input date carries no weekday, ordinal day or weekend flag
  a_inv_date_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && err == cdsu_pkg::ERR_DATE) |->
      (wd == 3'd0 && doy == 9'd0 && !m_axis_tdata[41]))
    else $error("invalid date result carries derived fields");

  a_weekend_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[41] == (wd == cdsu_pkg::WD_FRIDAY || wd == cdsu_pkg::WD_SATURDAY)))
    else $error("weekend flag disagrees with weekday");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (err != 2'd3 && wd <= 3'd6 && doy <= 9'd366 && m_axis_tdata[39:35] <= 5'd31))
    else $error("result field out of range");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind calendar_date_step_unit cdsu_checker u_cdsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/calendar_date_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_step_unit_tb: self-checking bench for the date step pipeline
// Streams directed corner dates and then random dates through the block while
// both sides idle at random. Every accepted request is predicted in the
// scoreboard, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module calendar_date_step_unit_tb;

  localparam int unsigned CYCLE_LIMIT        = 500000;
  localparam int          RANDOM_REQUESTS    = 1250;
  localparam int          OUTPUT_HOLD_CYCLES = 100;
  localparam int          DRAIN_CYCLES       = 20;
  localparam int          REPORT_LIMIT       = 10;

  // codes 5..7 are not decoded by the block and pass the date through
  localparam logic [2:0]  FUNC_FIRST_SPARE   = 3'd5;
  localparam logic [2:0]  FUNC_LAST_SPARE    = 3'd7;

  // packed to match s_axis_tdata[40:0], last field in the low bits
  typedef struct packed {
    logic signed [14:0] year_offset;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [2:0]         func;
  } date_req_t;

  // packed to match m_axis_tdata[43:0]
  typedef struct packed {
    cdsu_pkg::err_e error;
    logic           weekend;
    logic           leap_year;
    logic [4:0]     month_length;
    logic [8:0]     day_of_year;
    logic [2:0]     weekday;
    logic [4:0]     day;
    logic [3:0]     month;
    logic [13:0]    year;
  } date_res_t;

  class date_step_scoreboard;
    date_res_t expected_q[$];
    int        mismatches;
    int        results_seen;

    static function bit gregorian_leap(int y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int month_days(int y, int m);
      if (m < 1 || m > 12) return 0;
      if (m == cdsu_pkg::MONTH_FEB) return gregorian_leap(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    // March-based count; Jan and Feb belong to the previous year
    static function int day_of_week(int y, int m, int d);
      int a, yy, mm, s;
      a  = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      s  = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12;
      return s % 7;
    endfunction

    static function int ordinal_day(int y, int m, int d);
      int total;
      if (d < 1 || d > month_days(y, m)) return 0;
      total = d;
      for (int k = 1; k < m; k++) total += month_days(y, k);
      return total;
    endfunction

    static function date_res_t derive_fields(int y, int m, int d, cdsu_pkg::err_e err);
      date_res_t r;
      int wd;
      wd             = day_of_week(y, m, d);
      r.year         = 14'(y);
      r.month        = 4'(m);
      r.day          = 5'(d);
      r.weekday      = 3'(wd);
      r.day_of_year  = 9'(ordinal_day(y, m, d));
      r.month_length = 5'(month_days(y, m));
      r.leap_year    = gregorian_leap(y);
      r.weekend      = (wd == cdsu_pkg::WD_FRIDAY) || (wd == cdsu_pkg::WD_SATURDAY);
      r.error        = err;
      return r;
    endfunction

    static function date_res_t step_date(date_req_t rq);
      date_res_t r;
      int y, m, d, off, ny, nm, nd;
      y   = rq.year;
      m   = rq.month;
      d   = rq.day;
      off = rq.year_offset;
      ny  = y;
      nm  = m;
      nd  = d;
      if (y < int'(cdsu_pkg::YEAR_MIN) || y > int'(cdsu_pkg::YEAR_MAX) ||
          d < 1 || d > month_days(y, m)) begin
        r              = '0;
        r.year         = rq.year;
        r.month        = rq.month;
        r.day          = rq.day;
        r.month_length = 5'(month_days(y, m));
        r.leap_year    = gregorian_leap(y);
        r.error        = cdsu_pkg::ERR_DATE;
        return r;
      end
      case (rq.func)
        cdsu_pkg::FUNC_NEXT_DAY: begin
          if (d == month_days(y, m)) begin
            nd = 1;
            if (m == cdsu_pkg::MONTH_DEC) begin
              nm = cdsu_pkg::MONTH_JAN;
              ny = y + 1;
            end else begin
              nm = m + 1;
            end
          end else begin
            nd = d + 1;
          end
        end
        cdsu_pkg::FUNC_PREV_DAY: begin
          if (d == 1) begin
            if (m == cdsu_pkg::MONTH_JAN) begin
              ny = y - 1;
              nm = cdsu_pkg::MONTH_DEC;
              nd = cdsu_pkg::DAYS_DEC;
            end else begin
              nm = m - 1;
              nd = month_days(y, nm);
            end
          end else begin
            nd = d - 1;
          end
        end
        cdsu_pkg::FUNC_NEXT_MONTH, cdsu_pkg::FUNC_PREV_MONTH: begin
          if (rq.func == cdsu_pkg::FUNC_NEXT_MONTH) begin
            if (m == cdsu_pkg::MONTH_DEC) begin
              nm = cdsu_pkg::MONTH_JAN;
              ny = y + 1;
            end else begin
              nm = m + 1;
            end
          end else begin
            if (m == cdsu_pkg::MONTH_JAN) begin
              nm = cdsu_pkg::MONTH_DEC;
              ny = y - 1;
            end else begin
              nm = m - 1;
            end
          end
          if (nd > month_days(ny, nm)) nd = month_days(ny, nm);
        end
        cdsu_pkg::FUNC_ADD_YEARS: ny = y + off;
        default: ;
      endcase
      if (ny < int'(cdsu_pkg::YEAR_MIN) || ny > int'(cdsu_pkg::YEAR_MAX)) begin
        return derive_fields(y, m, d, cdsu_pkg::ERR_RANGE);
      end
      return derive_fields(ny, nm, nd, cdsu_pkg::ERR_OK);
    endfunction

    function void note_request(date_req_t rq);
      expected_q.push_back(step_date(rq));
    endfunction

    function bit field_differs(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b0;
      if (mismatches < REPORT_LIMIT)
        $display("result %0d %s: expected %0d, got %0d", results_seen, name, want, got);
      return 1'b1;
    endfunction

    function void check_result(logic [47:0] data);
      date_res_t want, got;
      bit bad;
      got = data[43:0];
      results_seen++;
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("result %0d arrived with no request pending: %h", results_seen, data);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      bad  = 1'b0;
      bad |= field_differs("new_year", want.year, got.year);
      bad |= field_differs("new_month", want.month, got.month);
      bad |= field_differs("new_day", want.day, got.day);
      bad |= field_differs("weekday", want.weekday, got.weekday);
      bad |= field_differs("day_of_year", want.day_of_year, got.day_of_year);
      bad |= field_differs("month_length", want.month_length, got.month_length);
      bad |= field_differs("leap_year", want.leap_year, got.leap_year);
      bad |= field_differs("weekend", want.weekend, got.weekend);
      bad |= field_differs("error", want.error, got.error);
      bad |= field_differs("padding", 0, data[47:44]);
      if (bad) mismatches++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  date_step_scoreboard board = new();
  bit          hold_output_request = 1'b0;
  bit          output_hold_active  = 1'b0;
  int unsigned cycle_count         = 0;

  calendar_date_step_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  function automatic date_req_t make_request(logic [2:0] f, int y, int m, int d, int off);
    date_req_t rq;
    rq.func        = f;
    rq.year        = 14'(y);
    rq.month       = 4'(m);
    rq.day         = 5'(d);
    rq.year_offset = 15'(off);
    return rq;
  endfunction

  // mostly valid dates near month, year and range edges, some raw noise
  function automatic date_req_t random_request();
    int r, y, m, d, off, ml;
    logic [2:0] f;
    r = $urandom_range(0, 99);
    if (r < 10)      y = $urandom_range(0, 16383);
    else if (r < 20) y = (r % 2) ? $urandom_range(1, 2) : $urandom_range(9998, 9999);
    else if (r < 30) y = 100 * $urandom_range(1, 99);
    else             y = $urandom_range(cdsu_pkg::YEAR_MIN, cdsu_pkg::YEAR_MAX);
    m  = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    ml = date_step_scoreboard::month_days(y, m);
    r  = $urandom_range(0, 99);
    if (ml == 0 || r < 8) d = $urandom_range(0, 31);
    else if (r < 35)      d = (r % 2) ? 1 : ml;
    else                  d = $urandom_range(1, ml);
    f = ($urandom_range(0, 99) < 92)
        ? 3'($urandom_range(cdsu_pkg::FUNC_NEXT_DAY, cdsu_pkg::FUNC_ADD_YEARS))
        : 3'($urandom_range(FUNC_FIRST_SPARE, FUNC_LAST_SPARE));
    r = $urandom_range(0, 99);
    if (r < 30) begin
      off = $urandom_range(0, 20) - 10;
    end else if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       off = 1 - y;
        1:       off = 9999 - y;
        2:       off = -y;
        default: off = 10000 - y;
      endcase
    end else if (r < 80) begin
      off = $urandom_range(0, 19998) - 9999;
    end else begin
      off = $urandom_range(0, 32767);
    end
    return make_request(f, y, m, d, off);
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // called right after a rising edge; returns once the request is taken
  task automatic send_request(date_req_t rq, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'b0, rq};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(rq);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // result side: ready runs, random stalls, one long hold on request
  initial begin
    int run, stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_output_request) begin
        m_axis_tready <= 1'b0;
        output_hold_active = 1'b1;
        repeat (OUTPUT_HOLD_CYCLES) @(posedge clk_i);
        output_hold_active  = 1'b0;
        hold_output_request = 1'b0;
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(40, 150);
      for (int k = 0; k < run && !hold_output_request; k++) @(posedge clk_i);
      stall = stall_length();
      if (stall > 0 && !hold_output_request) begin
        m_axis_tready <= 1'b0;
        for (int k = 0; k < stall && !hold_output_request; k++) @(posedge clk_i);
      end
    end
  end

  initial begin
    date_req_t directed_q[$];
    int gap;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // leap day, month ends, year ends and the range limits
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_DAY, 2024, 2, 28, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_DAY, 2023, 2, 28, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_DAY, 9999, 12, 31, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_DAY, 1999, 12, 31, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_DAY, 1, 1, 1, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_DAY, 2000, 1, 1, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_DAY, 2024, 3, 1, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_MONTH, 2023, 1, 31, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_MONTH, 9999, 12, 15, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_MONTH, 2024, 3, 31, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_MONTH, 1, 1, 31, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_MONTH, 2021, 1, 10, 0));
    // Feb 29 moved into a common year stays Feb 29 with no ordinal day
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 2024, 2, 29, 1));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 1, 1, 1, 9998));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 9999, 12, 31, -9998));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 5000, 6, 15, 16383));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 5000, 6, 15, -16384));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 1900, 2, 28, 100));
    for (int f = FUNC_FIRST_SPARE; f <= FUNC_LAST_SPARE; f++)
      directed_q.push_back(make_request(3'(f), 2020, 5, 5, 3));
    // invalid dates pass through with the date error
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_DAY, 0, 1, 1, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_ADD_YEARS, 16383, 15, 31, -1));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_DAY, 2023, 2, 29, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_DAY, 2020, 0, 0, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_NEXT_MONTH, 2020, 13, 10, 0));
    directed_q.push_back(make_request(cdsu_pkg::FUNC_PREV_MONTH, 2020, 4, 31, 0));
    foreach (directed_q[i]) send_request(directed_q[i], sender_gap());
    wait_for_drain();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 300) begin
        // stall the output long enough that the input backs up
        hold_output_request = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (!output_hold_active);
      end
      if (i == 700) wait_for_drain();
      gap = ((i % 250) < 60 || (i >= 300 && i < 360)) ? 0 : sender_gap();
      send_request(random_request(), gap);
    end
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
